[design/lbim_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Letterbox inverse mapper package
// Field widths, register indexes, reset values and default parameters shared
// by the mapper's modules.
// ----------------------------------------------------------------------------
package lbim_pkg;

  // Default fixed-point formats.
  localparam int unsigned COORD_FRAC_BITS_DEF = 4;
  localparam int unsigned SCALE_FRAC_BITS_DEF = 16;

  // Register widths.
  localparam int unsigned PAD_W   = 16;
  localparam int unsigned SCALE_W = 20;
  localparam int unsigned PIX_W   = 13;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  // Payload widths.
  localparam int unsigned IN_C_W  = 18;
  localparam int unsigned IN_E_W  = 17;
  localparam int unsigned OUT_W   = 17;
  // Far corner: signed coordinate plus unsigned extent.
  localparam int unsigned CORNER_W = IN_C_W + 1;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PAD_LEFT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_TOP       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE_SCALE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROI_OFFSET_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROI_OFFSET_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd6;

  // Register reset values.
  localparam logic [PAD_W-1:0]   PAD_RST    = 16'd0;
  localparam logic [SCALE_W-1:0] SCALE_RST  = 20'd65536;
  localparam logic [PIX_W-1:0]   OFFSET_RST = 13'd0;
  localparam logic [PIX_W-1:0]   WIDTH_RST  = 13'd1920;
  localparam logic [PIX_W-1:0]   HEIGHT_RST = 13'd1080;

  // Item kinds.
  localparam logic KIND_BOX   = 1'b0;
  localparam logic KIND_POINT = 1'b1;

endpackage

[design/lbim_axis.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Letterbox inverse mapper, one-corner axis unit
// Removes the padding, scales by the reciprocal, adds the crop offset and
// clamps the coordinate to 0 .. frame size.
// ----------------------------------------------------------------------------
module lbim_axis #(
  parameter int unsigned COORD_FRAC_BITS = lbim_pkg::COORD_FRAC_BITS_DEF,
  parameter int unsigned SCALE_FRAC_BITS = lbim_pkg::SCALE_FRAC_BITS_DEF,
  parameter int unsigned LIM_W           = lbim_pkg::PIX_W + COORD_FRAC_BITS
) (
  input  logic signed [lbim_pkg::CORNER_W-1:0] coord_i,
  input  logic        [lbim_pkg::PAD_W-1:0]    pad_i,
  input  logic        [lbim_pkg::SCALE_W-1:0]  scale_i,
  input  logic        [lbim_pkg::PIX_W-1:0]    offset_i,
  input  logic        [lbim_pkg::PIX_W-1:0]    size_i,
  output logic        [LIM_W-1:0]              coord_o
);

  // Difference, product and post-shift widths.
  localparam int unsigned D_W  = lbim_pkg::CORNER_W + 1;
  localparam int unsigned P_W  = D_W + lbim_pkg::SCALE_W + 1;
  localparam int unsigned SH_W = P_W - SCALE_FRAC_BITS;
  localparam int unsigned V_W  = ((SH_W > LIM_W + 1) ? SH_W : LIM_W + 1) + 1;

  logic signed [D_W-1:0]   diff;
  logic signed [P_W-1:0]   prod;
  logic signed [SH_W-1:0]  shifted;
  logic        [V_W-1:0]   off_ext;
  logic signed [V_W-1:0]   val;
  logic        [LIM_W-1:0] limit;

  // Padding removal.
  assign diff = D_W'(coord_i) - $signed({1'b0, {(D_W - lbim_pkg::PAD_W - 1){1'b0}}, pad_i});

  // Reciprocal scale multiply; the arithmetic shift floors toward minus infinity.
  assign prod    = P_W'(diff) * $signed({{(P_W - lbim_pkg::SCALE_W){1'b0}}, scale_i});
  assign shifted = prod[P_W-1:SCALE_FRAC_BITS];

  // Crop offset, in the coordinate's fixed-point format.
  assign off_ext = V_W'(offset_i) << COORD_FRAC_BITS;
  assign val     = V_W'(shifted) + $signed(off_ext);

  // Clamp to the frame.
  assign limit = LIM_W'(size_i) << COORD_FRAC_BITS;

  always_comb begin
    if (val[V_W-1]) begin
      coord_o = '0;
    end else if ($unsigned(val) > V_W'(limit)) begin
      coord_o = limit;
    end else begin
      coord_o = val[LIM_W-1:0];
    end
  end

endmodule

[design/letterbox_box_inverse_mapper.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Letterbox box inverse mapper
// Maps a detector-space box or landmark point back into the original frame.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                 Payload
//  input    in         in_valid_i / in_stall_o   kind_i, in_x_i, in_y_i, in_w_i, in_h_i
//  output   out        out_valid_o / out_stall_i out_x_o, out_y_o, out_w_o, out_h_o
//  config   in         cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One transaction per cycle sustained while the output is not stalled. A result
// passes through the input register and then the result register before it is
// presented. The cycle is set by the path from the input register through the
// 20 x 21 multiply, the offset add and the clamp. Reset clears both valid flags
// and loads the register reset values. A stall on the output holds the result
// register and, once the input register is full too, stalls the input.
// ----------------------------------------------------------------------------
module letterbox_box_inverse_mapper #(
  parameter int unsigned COORD_FRAC_BITS = lbim_pkg::COORD_FRAC_BITS_DEF,
  parameter int unsigned SCALE_FRAC_BITS = lbim_pkg::SCALE_FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration port.
  input  logic                                cfg_we_i,
  input  logic [lbim_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lbim_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // Input channel.
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                kind_i,
  input  logic signed [lbim_pkg::IN_C_W-1:0]  in_x_i,
  input  logic signed [lbim_pkg::IN_C_W-1:0]  in_y_i,
  input  logic [lbim_pkg::IN_E_W-1:0]         in_w_i,
  input  logic [lbim_pkg::IN_E_W-1:0]         in_h_i,
  // Output channel.
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [lbim_pkg::OUT_W-1:0]          out_x_o,
  output logic [lbim_pkg::OUT_W-1:0]          out_y_o,
  output logic [lbim_pkg::OUT_W-1:0]          out_w_o,
  output logic [lbim_pkg::OUT_W-1:0]          out_h_o
);

  localparam int unsigned LIM_W = lbim_pkg::PIX_W + COORD_FRAC_BITS;
  localparam int unsigned C_W   = lbim_pkg::CORNER_W;

  // Configuration registers.
  logic [lbim_pkg::PAD_W-1:0]   pad_left_q, pad_top_q;
  logic [lbim_pkg::SCALE_W-1:0] inv_scale_q;
  logic [lbim_pkg::PIX_W-1:0]   roi_x_q, roi_y_q, frame_w_q, frame_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_left_q  <= lbim_pkg::PAD_RST;
      pad_top_q   <= lbim_pkg::PAD_RST;
      inv_scale_q <= lbim_pkg::SCALE_RST;
      roi_x_q     <= lbim_pkg::OFFSET_RST;
      roi_y_q     <= lbim_pkg::OFFSET_RST;
      frame_w_q   <= lbim_pkg::WIDTH_RST;
      frame_h_q   <= lbim_pkg::HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lbim_pkg::REG_PAD_LEFT:      pad_left_q  <= cfg_data_i[lbim_pkg::PAD_W-1:0];
        lbim_pkg::REG_PAD_TOP:       pad_top_q   <= cfg_data_i[lbim_pkg::PAD_W-1:0];
        lbim_pkg::REG_INVERSE_SCALE: inv_scale_q <= cfg_data_i[lbim_pkg::SCALE_W-1:0];
        lbim_pkg::REG_ROI_OFFSET_X:  roi_x_q     <= cfg_data_i[lbim_pkg::PIX_W-1:0];
        lbim_pkg::REG_ROI_OFFSET_Y:  roi_y_q     <= cfg_data_i[lbim_pkg::PIX_W-1:0];
        lbim_pkg::REG_FRAME_WIDTH:   frame_w_q   <= cfg_data_i[lbim_pkg::PIX_W-1:0];
        lbim_pkg::REG_FRAME_HEIGHT:  frame_h_q   <= cfg_data_i[lbim_pkg::PIX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Pipeline flow control: the result register advances when empty or taken,
  // and the input register advances whenever it can hand its item on.
  logic in_valid_q, out_valid_q;
  logic out_en, in_en;

  assign out_en     = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !out_en;
  assign in_en      = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_en) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Input register.
  logic                              kind_q;
  logic signed [lbim_pkg::IN_C_W-1:0] x_q, y_q;
  logic [lbim_pkg::IN_E_W-1:0]        w_q, h_q;

  always_ff @(posedge clk_i) begin
    if (in_en) begin
      kind_q <= kind_i;
      x_q    <= in_x_i;
      y_q    <= in_y_i;
      w_q    <= in_w_i;
      h_q    <= in_h_i;
    end
  end

  // Near and far corners.
  logic signed [C_W-1:0] x1, y1, x2, y2;

  assign x1 = C_W'(x_q);
  assign y1 = C_W'(y_q);
  assign x2 = C_W'(x_q) + $signed({{(C_W - lbim_pkg::IN_E_W){1'b0}}, w_q});
  assign y2 = C_W'(y_q) + $signed({{(C_W - lbim_pkg::IN_E_W){1'b0}}, h_q});

  // One axis unit per corner coordinate.
  logic [LIM_W-1:0] mx1, my1, mx2, my2;

  lbim_axis #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS),
    .SCALE_FRAC_BITS(SCALE_FRAC_BITS),
    .LIM_W          (LIM_W)
  ) u_axis_x1 (
    .coord_i (x1),
    .pad_i   (pad_left_q),
    .scale_i (inv_scale_q),
    .offset_i(roi_x_q),
    .size_i  (frame_w_q),
    .coord_o (mx1)
  );

  lbim_axis #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS),
    .SCALE_FRAC_BITS(SCALE_FRAC_BITS),
    .LIM_W          (LIM_W)
  ) u_axis_y1 (
    .coord_i (y1),
    .pad_i   (pad_top_q),
    .scale_i (inv_scale_q),
    .offset_i(roi_y_q),
    .size_i  (frame_h_q),
    .coord_o (my1)
  );

  lbim_axis #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS),
    .SCALE_FRAC_BITS(SCALE_FRAC_BITS),
    .LIM_W          (LIM_W)
  ) u_axis_x2 (
    .coord_i (x2),
    .pad_i   (pad_left_q),
    .scale_i (inv_scale_q),
    .offset_i(roi_x_q),
    .size_i  (frame_w_q),
    .coord_o (mx2)
  );

  lbim_axis #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS),
    .SCALE_FRAC_BITS(SCALE_FRAC_BITS),
    .LIM_W          (LIM_W)
  ) u_axis_y2 (
    .coord_i (y2),
    .pad_i   (pad_top_q),
    .scale_i (inv_scale_q),
    .offset_i(roi_y_q),
    .size_i  (frame_h_q),
    .coord_o (my2)
  );

  // Extent from the clamped corners; a landmark point has no extent.
  logic [LIM_W-1:0] ext_w, ext_h;

  always_comb begin
    ext_w = '0;
    ext_h = '0;
    if (kind_q == lbim_pkg::KIND_BOX) begin
      if (mx2 >= mx1) begin
        ext_w = mx2 - mx1;
      end
      if (my2 >= my1) begin
        ext_h = my2 - my1;
      end
    end
  end

  // Result register.
  logic [lbim_pkg::OUT_W-1:0] out_x_q, out_y_q, out_w_q, out_h_q;

  always_ff @(posedge clk_i) begin
    if (out_en && in_valid_q) begin
      out_x_q <= lbim_pkg::OUT_W'(mx1);
      out_y_q <= lbim_pkg::OUT_W'(my1);
      out_w_q <= lbim_pkg::OUT_W'(ext_w);
      out_h_q <= lbim_pkg::OUT_W'(ext_h);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_w_o     = out_w_q;
  assign out_h_o     = out_h_q;

endmodule
